[src/owtm_pkg.sv]
// Shared types and constants of the single-wire temperature master.
// Used by owtm_front, owtm_fifo, owtm_back and the top level.
`default_nettype none

package owtm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_TEMP  = 3'd4
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       line_in;
    } t_item;

    typedef struct packed {
        logic [15:0] temperature;
        logic        no_presence;
        logic [7:0]  rx_byte;
        logic        done_res;
        logic        busy_res;
        logic        line_low;
    } t_result;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;
    localparam int RES_W       = $bits(t_result);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_WAIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PRES_WAIT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PRES_LOW     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_LOW     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_READ_RECOV   = 3'd7;

    localparam logic [9:0] RST_RESET_LOW    = 10'd750;
    localparam logic [7:0] RST_RELEASE_WAIT = 8'd15;
    localparam logic [7:0] RST_PRES_WAIT    = 8'd201;
    localparam logic [7:0] RST_PRES_LOW     = 8'd240;
    localparam logic [5:0] RST_SHORT_LOW    = 6'd2;
    localparam logic [6:0] RST_LONG_LOW     = 7'd60;
    localparam logic [5:0] RST_READ_SAMPLE  = 6'd12;
    localparam logic [6:0] RST_READ_RECOV   = 7'd50;

    localparam logic [7:0] ROM_SKIP     = 8'hCC;
    localparam logic [7:0] CONVERT_T    = 8'h44;
    localparam logic [7:0] READ_PAD     = 8'hBE;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

`default_nettype wire

[src/one_wire_temperature_master_unit.sv]
// Top level of the single-wire temperature master.
// Instantiates owtm_front, owtm_fifo and owtm_back; depends on owtm_pkg.
//
//  port group   dir  fields (lowest bit first)
//  s_axis       in   tdata: tx_byte[7:0], line_in[8]; tuser: command[2:0]
//  m_axis       out  tdata: line_low, busy_res, done_res, rx_byte[7:0],
//                          no_presence, temperature[15:0]
//  i_cfg_*      in   register index [2:0], write data [9:0]
//
// One tick word in, one result word out, one word per cycle sustained while m_axis is ready.
// The result register is loaded from the queue head on each pop; a four-word queue
// sits between decode and the bus engine.
// Synchronous active-low reset loads the default timings and idles the engine.
// A stall on m_axis holds the engine; s_axis keeps taking words until the queue fills.
`default_nettype none

module one_wire_temperature_master_unit
    import owtm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // tx_byte, line_in
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // command
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // line_low, busy_res, done_res,
                                                       // rx_byte, no_presence, temperature
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;
    t_item   w_in_item;
    t_item   w_head;
    t_result w_res;

    owtm_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    owtm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    owtm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_item      (w_head),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_res)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-RES_W)'(0), w_res};

endmodule

`default_nettype wire

[src/owtm_front.sv]
// Front end: takes input words and decodes the command field.
// Depends on owtm_pkg; feeds owtm_fifo.
`default_nettype none

module owtm_front
    import owtm_pkg::*;
(
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic [IN_TUSER_W-1:0] i_tuser,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_item                      o_item
);

    t_cmd w_cmd;

    always_comb begin
        case (i_tuser)
            CMD_RESET: w_cmd = CMD_RESET;
            CMD_WRITE: w_cmd = CMD_WRITE;
            CMD_READ:  w_cmd = CMD_READ;
            CMD_TEMP:  w_cmd = CMD_TEMP;
            default:   w_cmd = CMD_NONE;
        endcase
    end

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign o_item   = '{cmd: w_cmd, tx_byte: i_tdata[7:0], line_in: i_tdata[8]};

endmodule

`default_nettype wire

[src/owtm_fifo.sv]
// Short queue of decoded ticks between front end and bus engine.
// Depends on owtm_pkg.
`default_nettype none

module owtm_fifo
    import owtm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_item       o_item
);

    t_item               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

[src/owtm_back.sv]
// Bus engine: slot timing, presence check, byte shifter, temperature sequence.
// Holds the timing registers and the result register. Depends on owtm_pkg.
`default_nettype none

module owtm_back
    import owtm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_empty,
    input  wire t_item                 i_item,
    output logic                       o_pop,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output t_result                    o_out
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_PRES_HIGH, PH_PRES_LOW,
        PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
    } t_phase;

    localparam logic [3:0] STEP_RST_A  = 4'd0;
    localparam logic [3:0] STEP_SKIP_A = 4'd1;
    localparam logic [3:0] STEP_CONV   = 4'd2;
    localparam logic [3:0] STEP_RST_B  = 4'd3;
    localparam logic [3:0] STEP_SKIP_B = 4'd4;
    localparam logic [3:0] STEP_PAD    = 4'd5;
    localparam logic [3:0] STEP_LOW    = 4'd6;
    localparam logic [3:0] STEP_HIGH   = 4'd7;

    logic [9:0]  r_reset_low;
    logic [7:0]  r_release_wait;
    logic [7:0]  r_pres_wait;
    logic [7:0]  r_pres_low;
    logic [5:0]  r_short_low;
    logic [6:0]  r_long_low;
    logic [5:0]  r_read_sample;
    logic [6:0]  r_read_recov;

    t_phase      r_phase,  n_phase;
    logic [9:0]  r_tick,   n_tick;
    logic [2:0]  r_bit,    n_bit;
    logic [7:0]  r_shift,  n_shift;
    logic [3:0]  r_step,   n_step;
    logic [7:0]  r_low,    n_low;
    logic [15:0] r_temp,   n_temp;
    logic        r_pfail,  n_pfail;
    t_cmd        r_act,    n_act;
    logic [7:0]  r_rx,     n_rx;
    logic        r_out_valid;
    t_result     r_out,    n_out;

    logic        w_drive;
    logic        w_done;
    logic        w_sub_done;
    logic [9:0]  w_dur;

    assign o_pop       = !i_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_step     = r_step;
        n_low      = r_low;
        n_temp     = r_temp;
        n_pfail    = r_pfail;
        n_act      = r_act;
        n_rx       = r_rx;
        w_drive    = 1'b0;
        w_done     = 1'b0;
        w_sub_done = 1'b0;
        w_dur      = '0;

        if (r_phase == PH_IDLE && i_item.cmd != CMD_NONE) begin
            n_act  = i_item.cmd;
            n_step = STEP_RST_A;
            n_tick = '0;
            case (i_item.cmd)
                CMD_RESET, CMD_TEMP: begin
                    n_pfail = 1'b0;
                    n_phase = PH_RST_LOW;
                end
                CMD_WRITE: begin
                    n_shift = i_item.tx_byte;
                    n_bit   = '0;
                    n_phase = PH_WR_LOW;
                end
                default: begin
                    n_shift = '0;
                    n_bit   = '0;
                    n_phase = PH_RD_LOW;
                end
            endcase
        end

        n_out.busy_res = (n_phase != PH_IDLE);

        case (n_phase)
            PH_RST_LOW: begin
                w_drive = 1'b1;
                n_tick  = n_tick + 10'd1;
                if (n_tick >= r_reset_low) begin
                    n_phase = PH_RST_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RST_WAIT: begin
                n_tick = n_tick + 10'd1;
                if (n_tick >= {2'b0, r_release_wait}) begin
                    n_phase = PH_PRES_HIGH;
                    n_tick  = '0;
                end
            end
            PH_PRES_HIGH: begin
                if (i_item.line_in) begin
                    if (n_tick >= {2'b0, r_pres_wait}) begin
                        n_pfail    = 1'b1;
                        w_sub_done = 1'b1;
                    end else begin
                        n_tick = n_tick + 10'd1;
                    end
                end else if (r_pres_low == '0) begin
                    n_pfail    = 1'b1;
                    w_sub_done = 1'b1;
                end else begin
                    n_phase = PH_PRES_LOW;
                    n_tick  = 10'd1;
                end
            end
            PH_PRES_LOW: begin
                if (i_item.line_in) begin
                    w_sub_done = 1'b1;
                end else if (n_tick >= {2'b0, r_pres_low}) begin
                    n_pfail    = 1'b1;
                    w_sub_done = 1'b1;
                end else begin
                    n_tick = n_tick + 10'd1;
                end
            end
            PH_WR_LOW: begin
                w_drive = 1'b1;
                w_dur   = n_shift[n_bit] ? {4'b0, r_short_low} : {3'b0, r_long_low};
                n_tick  = n_tick + 10'd1;
                if (n_tick >= w_dur) begin
                    n_phase = PH_WR_HIGH;
                    n_tick  = '0;
                end
            end
            PH_WR_HIGH: begin
                w_dur  = n_shift[n_bit] ? {3'b0, r_long_low} : {4'b0, r_short_low};
                n_tick = n_tick + 10'd1;
                if (n_tick >= w_dur) begin
                    if (n_bit == 3'd7) begin
                        w_sub_done = 1'b1;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = PH_WR_LOW;
                        n_tick  = '0;
                    end
                end
            end
            PH_RD_LOW: begin
                w_drive = 1'b1;
                n_tick  = n_tick + 10'd1;
                if (n_tick >= {4'b0, r_short_low}) begin
                    n_phase = PH_RD_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RD_WAIT: begin
                n_tick = n_tick + 10'd1;
                if (n_tick >= {4'b0, r_read_sample}) begin
                    n_phase = PH_RD_REC;
                    n_tick  = '0;
                end
            end
            PH_RD_REC: begin
                if (n_tick == '0) begin
                    n_shift = {i_item.line_in, n_shift[7:1]};
                end
                n_tick = n_tick + 10'd1;
                if (n_tick >= {3'b0, r_read_recov}) begin
                    if (n_bit == 3'd7) begin
                        n_rx       = n_shift;
                        w_sub_done = 1'b1;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = PH_RD_LOW;
                        n_tick  = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        if (w_sub_done) begin
            n_tick = '0;
            if (n_act == CMD_TEMP && n_step < STEP_HIGH) begin
                if (n_step == STEP_LOW) begin
                    n_low = n_shift;
                end
                n_step = n_step + 4'd1;
                case (n_step)
                    STEP_RST_A, STEP_RST_B: begin
                        n_phase = PH_RST_LOW;
                    end
                    STEP_SKIP_A, STEP_SKIP_B: begin
                        n_shift = ROM_SKIP;
                        n_bit   = '0;
                        n_phase = PH_WR_LOW;
                    end
                    STEP_CONV: begin
                        n_shift = CONVERT_T;
                        n_bit   = '0;
                        n_phase = PH_WR_LOW;
                    end
                    STEP_PAD: begin
                        n_shift = READ_PAD;
                        n_bit   = '0;
                        n_phase = PH_WR_LOW;
                    end
                    default: begin
                        n_shift = '0;
                        n_bit   = '0;
                        n_phase = PH_RD_LOW;
                    end
                endcase
            end else begin
                if (n_act == CMD_TEMP) begin
                    n_temp = {n_shift, n_low};
                end
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end
        end

        n_out.line_low    = w_drive;
        n_out.done_res    = w_done;
        n_out.rx_byte     = n_rx;
        n_out.no_presence = n_pfail;
        n_out.temperature = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low    <= RST_RESET_LOW;
            r_release_wait <= RST_RELEASE_WAIT;
            r_pres_wait    <= RST_PRES_WAIT;
            r_pres_low     <= RST_PRES_LOW;
            r_short_low    <= RST_SHORT_LOW;
            r_long_low     <= RST_LONG_LOW;
            r_read_sample  <= RST_READ_SAMPLE;
            r_read_recov   <= RST_READ_RECOV;
            r_phase        <= PH_IDLE;
            r_tick         <= '0;
            r_bit          <= '0;
            r_shift        <= '0;
            r_step         <= '0;
            r_low          <= '0;
            r_temp         <= '0;
            r_pfail        <= 1'b0;
            r_act          <= CMD_NONE;
            r_rx           <= '0;
            r_out_valid    <= 1'b0;
            r_out          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RESET_LOW:    r_reset_low    <= i_cfg_wdata;
                    REG_RELEASE_WAIT: r_release_wait <= i_cfg_wdata[7:0];
                    REG_PRES_WAIT:    r_pres_wait    <= i_cfg_wdata[7:0];
                    REG_PRES_LOW:     r_pres_low     <= i_cfg_wdata[7:0];
                    REG_SHORT_LOW:    r_short_low    <= i_cfg_wdata[5:0];
                    REG_LONG_LOW:     r_long_low     <= i_cfg_wdata[6:0];
                    REG_READ_SAMPLE:  r_read_sample  <= i_cfg_wdata[5:0];
                    REG_READ_RECOV:   r_read_recov   <= i_cfg_wdata[6:0];
                    default:          r_read_recov   <= r_read_recov;
                endcase
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_step      <= n_step;
                r_low       <= n_low;
                r_temp      <= n_temp;
                r_pfail     <= n_pfail;
                r_act       <= n_act;
                r_rx        <= n_rx;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_out.done_res |=> r_phase == PH_IDLE)
        else $error("engine not idle after completion");

    a_drive_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.line_low |-> r_out.busy_res)
        else $error("bus driven while not busy");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_phase == PH_IDLE && i_item.cmd == CMD_NONE
        |=> r_phase == PH_IDLE && !r_out.busy_res && !r_out.line_low)
        else $error("engine left idle without a command");

endmodule

`default_nettype wire
